// ----- rtl/octal_escape_byte_codec_macros.svh -----
// Assertion macros for the octal escape byte codec checker.
// No dependencies; taken in by the checker file only.
`ifndef OCTAL_ESCAPE_BYTE_CODEC_MACROS_SVH
`define OCTAL_ESCAPE_BYTE_CODEC_MACROS_SVH

// same-cycle implication, disabled during reset
`define OEBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oebc check failed");

// next-cycle implication, disabled during reset
`define OEBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oebc check failed");

`endif

// ----- rtl/oebc_pkg.sv -----
// Shared types and constants for the octal escape byte codec.
// No dependencies; imported by the front end, queue, back end, top level and testbench.
package oebc_pkg;

    localparam logic [7:0] BSLASH   = 8'h5C;
    localparam logic [7:0] DIGIT0   = 8'h30;
    localparam logic [7:0] DIGIT9   = 8'h39;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // command opcodes
    localparam logic [1:0] OP_ONE = 2'd0;   // one result
    localparam logic [1:0] OP_DBL = 2'd1;   // doubled backslash
    localparam logic [1:0] OP_OCT = 2'd2;   // backslash and three octal digits

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       bad;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/oebc_front.sv -----
// Front end: accepts input bytes, runs the decode escape state or classifies bytes
// for encoding, and issues commands. Depends on oebc_pkg.
module oebc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic            cmd_push,
    output oebc_pkg::cmd_t  cmd
);
    import oebc_pkg::*;

    // escape phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;   // outside an escape
    localparam logic [1:0] PH_OPEN = 2'd1;   // after a backslash
    localparam logic [1:0] PH_ONE  = 2'd2;   // after one digit
    localparam logic [1:0] PH_TWO  = 2'd3;   // after two digits

    logic       direction_reg;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] partial_reg, partial_next;
    logic       err_reg, err_next;

    logic       is_digit;
    logic [7:0] digit;
    logic [7:0] acc;
    logic       have;
    logic [7:0] data;
    logic       err_final;

    assign is_digit = (in_byte >= DIGIT0) && (in_byte <= DIGIT9);
    assign digit    = in_byte - DIGIT0;
    assign acc      = {partial_reg[4:0], 3'b000} + digit;

    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        err_next     = err_reg;
        have         = 1'b0;
        data         = 8'h00;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte == BSLASH)
                begin
                    phase_next = PH_OPEN;
                end
                else
                begin
                    have = 1'b1;
                    data = in_byte;
                end
            end
            PH_OPEN:
            begin
                if (in_byte == BSLASH)
                begin
                    have       = 1'b1;
                    data       = BSLASH;
                    phase_next = PH_IDLE;
                end
                else if (is_digit)
                begin
                    partial_next = digit;
                    phase_next   = PH_ONE;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_ONE:
            begin
                if (is_digit)
                begin
                    partial_next = acc;
                    phase_next   = PH_TWO;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                if (is_digit)
                begin
                    have = 1'b1;
                    data = acc;
                end
                else
                begin
                    err_next = 1'b1;
                end
                phase_next = PH_IDLE;
            end
        endcase
        // unfinished escape at end of string
        err_final = err_next | (phase_next != PH_IDLE);
    end

    always_comb
    begin
        cmd = '0;
        if (direction_reg)
        begin
            if (in_byte == BSLASH)
                cmd.op = OP_DBL;
            else if ((in_byte >= PRINT_LO) && (in_byte <= PRINT_HI))
                cmd.op = OP_ONE;
            else
                cmd.op = OP_OCT;
            cmd.data  = in_byte;
            cmd.valid = 1'b1;
            cmd.last  = in_last;
            cmd.bad   = 1'b0;
            cmd_push  = accept;
        end
        else
        begin
            cmd.op    = OP_ONE;
            cmd.data  = data;
            cmd.valid = have;
            cmd.last  = in_last;
            cmd.bad   = in_last & err_final;
            cmd_push  = accept & (have | in_last);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            partial_reg   <= 8'h00;
            err_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            direction_reg <= cfg_wdata;
            phase_reg     <= PH_IDLE;
            partial_reg   <= 8'h00;
            err_reg       <= 1'b0;
        end
        else if (accept && !direction_reg)
        begin
            if (in_last)
            begin
                phase_reg   <= PH_IDLE;
                partial_reg <= 8'h00;
                err_reg     <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                partial_reg <= partial_next;
                err_reg     <= err_next;
            end
        end
    end

endmodule

// ----- rtl/oebc_queue.sv -----
// Short command queue decoupling the front end from the back end.
// Depends on oebc_pkg.
module oebc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  oebc_pkg::cmd_t    wdata,
    input  logic              pop,
    output oebc_pkg::cmd_t    head,
    output oebc_pkg::q_stat_t stat
);
    import oebc_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/oebc_back.sv -----
// Back end: expands each command into result transactions, loaded into the output
// register one per cycle while it is empty or popped. Depends on oebc_pkg.
module oebc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  oebc_pkg::cmd_t    head,
    input  oebc_pkg::q_stat_t stat,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        out_byte,
    output logic              out_valid,
    output logic              out_last,
    output logic              bad_input
);
    import oebc_pkg::*;

    logic [1:0] beat_reg;
    logic       full_reg;
    logic [7:0] byte_reg;
    logic       valid_reg;
    logic       last_reg;
    logic       bad_reg;

    logic       load;
    logic       final_beat;
    logic [7:0] beat_byte;

    assign load  = !full_reg || pop;
    assign q_pop = load && !stat.empty && final_beat;

    always_comb
    begin
        beat_byte  = BSLASH;
        final_beat = 1'b0;
        unique case (head.op)
            OP_ONE:
            begin
                beat_byte  = head.data;
                final_beat = 1'b1;
            end
            OP_DBL:
            begin
                beat_byte  = BSLASH;
                final_beat = (beat_reg == 2'd1);
            end
            OP_OCT:
            begin
                case (beat_reg)
                    2'd0:    beat_byte = BSLASH;
                    2'd1:    beat_byte = DIGIT0 + {6'b0, head.data[7:6]};
                    2'd2:    beat_byte = DIGIT0 + {5'b0, head.data[5:3]};
                    default: beat_byte = DIGIT0 + {5'b0, head.data[2:0]};
                endcase
                final_beat = (beat_reg == 2'd3);
            end
            default:
            begin
                beat_byte  = head.data;
                final_beat = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load && !stat.empty)
        begin
            byte_reg  <= beat_byte;
            valid_reg <= head.valid;
            last_reg  <= head.last & final_beat;
            bad_reg   <= head.bad & final_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            beat_reg <= 2'd0;
        end
        else if (load)
        begin
            full_reg <= !stat.empty;
            if (!stat.empty)
                beat_reg <= final_beat ? 2'd0 : beat_reg + 2'd1;
        end
    end

    assign empty     = !full_reg;
    assign out_byte  = byte_reg;
    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign bad_input = bad_reg;

endmodule

// ----- rtl/octal_escape_byte_codec.sv -----
// Backslash-octal escape codec: front end, command queue of four, back end.
// Input: one byte a cycle while full is low; the front end queues commands. The back
// end puts one result a cycle into the output register while it is empty or popped,
// so an encoded backslash gives two results and an octal escape four, and the
// four-deep command queue fills (full rises) when such escapes follow each other.
// Reset (rst_n, asynchronous, active low) empties the queue and output, selects decode.
module octal_escape_byte_codec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       out_last,
    output logic       bad_input
);
    import oebc_pkg::*;

    cmd_t    cmd;
    cmd_t    head;
    q_stat_t stat;
    logic    cmd_push;
    logic    q_pop;
    logic    accept;

    assign full   = stat.full;
    assign accept = push && !stat.full;

    oebc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    oebc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd),
        .pop   (q_pop),
        .head  (head),
        .stat  (stat)
    );

    oebc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (stat),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_last  (out_last),
        .bad_input (bad_input)
    );

endmodule

// ----- rtl/oebc_checker.sv -----
// Port-level checks for the octal escape byte codec, bound to the top level.
// Depends on octal_escape_byte_codec_macros.svh.
`include "octal_escape_byte_codec_macros.svh"

module oebc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       out_valid,
    input logic       out_last,
    input logic       bad_input
);

    logic [10:0] res_bits;

    assign res_bits = {out_byte, out_valid, out_last, bad_input};

    // a waiting result holds until its transaction
    `OEBC_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(res_bits))
    // error flag only on the final result of a string
    `OEBC_ASSERT_NOW(a_bad_last, clk, rst_n, !empty && bad_input, out_last)
    // an end marker closes a string and carries a zero byte
    `OEBC_ASSERT_NOW(a_marker, clk, rst_n, !empty && !out_valid, out_last && (out_byte == 8'h00))

endmodule

bind octal_escape_byte_codec oebc_checker u_oebc_checker (.*);

// ----- test/tb_octal_escape_byte_codec.sv -----
// Self-checking testbench for octal_escape_byte_codec: queue-style driver and monitor,
// a bit-true predictor of both escape directions, random idling and a long receiver stall.
// Depends on oebc_pkg and the octal_escape_byte_codec RTL.
module tb_octal_escape_byte_codec;
    import oebc_pkg::*;

    localparam logic DIR_DECODE   = 1'b0;
    localparam logic DIR_ENCODE   = 1'b1;
    localparam int   DRAIN_CYCLES = 6;
    localparam int   LIMIT_CYCLES = 200000;
    localparam int   RANDOM_BYTES = 245;

    typedef enum logic [1:0] {ESC_IDLE, ESC_OPEN, ESC_ONE, ESC_TWO} esc_phase_e;
    typedef enum logic [1:0] {ACT_BYTE, ACT_DIR, ACT_SYNC} act_kind_e;

    typedef struct {
        act_kind_e  kind;
        logic [7:0] data;
        logic       last;
    } plan_entry_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       bad;
    } codec_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       push      = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       pop       = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       bad_input;

    plan_entry_t   plan[$];
    codec_result_t expected_results[$];

    // predictor state
    logic       dir_q = DIR_DECODE;
    esc_phase_e esc_q = ESC_IDLE;
    logic [7:0] acc_q = 8'h00;
    logic       err_q = 1'b0;

    int n_planned     = 0;
    int n_loaded      = 0;
    int n_accepted    = 0;
    int n_checked     = 0;
    int n_dir_writes  = 0;
    int n_bad_strings = 0;
    int fail_cnt      = 0;
    int tx_gap        = 0;
    int rx_gap        = 0;
    int quiet_cnt     = 0;
    int hold_cnt      = 0;
    int hold_seen     = 0;
    int cycle_cnt     = 0;
    logic hold_done   = 1'b0;

    octal_escape_byte_codec u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_last  (out_last),
        .bad_input (bad_input)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= DIGIT0) && (c <= DIGIT9);
    endfunction

    function automatic logic [7:0] pick_non_digit();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == BSLASH || is_dec(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic push_result(input logic [7:0] d, input logic v, input logic l,
                               input logic b);
        codec_result_t r;
        r.data  = d;
        r.valid = v;
        r.last  = l;
        r.bad   = b;
        expected_results.push_back(r);
    endtask

    task automatic escape_codec_predict(input logic [7:0] c, input logic fin);
        logic       have;
        logic [7:0] data;
        logic [7:0] d;
        have = 1'b0;
        data = 8'h00;
        d    = c - DIGIT0;
        if (dir_q == DIR_ENCODE)
        begin
            if (c == BSLASH)
            begin
                push_result(BSLASH, 1'b1, 1'b0, 1'b0);
                push_result(BSLASH, 1'b1, fin, 1'b0);
            end
            else if (c >= PRINT_LO && c <= PRINT_HI)
            begin
                push_result(c, 1'b1, fin, 1'b0);
            end
            else
            begin
                push_result(BSLASH, 1'b1, 1'b0, 1'b0);
                push_result(DIGIT0 + {6'd0, c[7:6]}, 1'b1, 1'b0, 1'b0);
                push_result(DIGIT0 + {5'd0, c[5:3]}, 1'b1, 1'b0, 1'b0);
                push_result(DIGIT0 + {5'd0, c[2:0]}, 1'b1, fin, 1'b0);
            end
        end
        else
        begin
            case (esc_q)
                ESC_IDLE:
                begin
                    if (c == BSLASH)
                        esc_q = ESC_OPEN;
                    else
                    begin
                        have = 1'b1;
                        data = c;
                    end
                end
                ESC_OPEN:
                begin
                    if (c == BSLASH)
                    begin
                        have  = 1'b1;
                        data  = BSLASH;
                        esc_q = ESC_IDLE;
                    end
                    else if (is_dec(c))
                    begin
                        acc_q = d;
                        esc_q = ESC_ONE;
                    end
                    else
                    begin
                        err_q = 1'b1;
                        esc_q = ESC_IDLE;
                    end
                end
                ESC_ONE:
                begin
                    if (is_dec(c))
                    begin
                        acc_q = (acc_q << 3) + d;
                        esc_q = ESC_TWO;
                    end
                    else
                    begin
                        err_q = 1'b1;
                        esc_q = ESC_IDLE;
                    end
                end
                default:
                begin
                    // third digit: value wraps modulo 256
                    if (is_dec(c))
                    begin
                        have = 1'b1;
                        data = (acc_q << 3) + d;
                    end
                    else
                        err_q = 1'b1;
                    esc_q = ESC_IDLE;
                end
            endcase
            if (!fin)
            begin
                if (have)
                    push_result(data, 1'b1, 1'b0, 1'b0);
            end
            else
            begin
                if (esc_q != ESC_IDLE)
                    err_q = 1'b1;
                push_result(have ? data : 8'h00, have, 1'b1, err_q);
                if (err_q)
                    n_bad_strings++;
                esc_q = ESC_IDLE;
                acc_q = 8'h00;
                err_q = 1'b0;
            end
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic fin);
        plan.push_back('{ACT_BYTE, b, fin});
        n_planned++;
    endtask

    task automatic add_dir(input logic dir);
        plan.push_back('{ACT_DIR, {7'd0, dir}, 1'b0});
    endtask

    task automatic add_sync();
        plan.push_back('{ACT_SYNC, 8'h00, 1'b0});
    endtask

    // escaped text: mostly well-formed tokens, some broken escapes
    task automatic gen_escaped_string();
        int         n_tok;
        int         kind;
        int         n_dig;
        logic       fin;
        logic [7:0] c;
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++)
        begin
            fin  = (t == n_tok - 1);
            kind = $urandom_range(0, 19);
            if (kind < 8)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == BSLASH)
                    c = 8'h00;
                add_byte(c, fin);
            end
            else if (kind < 11)
            begin
                add_byte(BSLASH, 1'b0);
                add_byte(BSLASH, fin);
            end
            else if (kind < 17)
            begin
                add_byte(BSLASH, 1'b0);
                for (int k = 0; k < 3; k++)
                begin
                    c = DIGIT0 + 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 9)
                                                                : $urandom_range(0, 7));
                    add_byte(c, fin && (k == 2));
                end
            end
            else if (kind == 17)
            begin
                add_byte(BSLASH, 1'b0);
                add_byte(pick_non_digit(), fin);
            end
            else if (kind == 18)
            begin
                add_byte(BSLASH, 1'b0);
                n_dig = $urandom_range(1, 2);
                for (int k = 0; k < n_dig; k++)
                    add_byte(DIGIT0 + 8'($urandom_range(0, 9)), 1'b0);
                add_byte(pick_non_digit(), fin);
            end
            else
            begin
                // escape cut short; at the end of a string it ends inside it
                n_dig = $urandom_range(0, 2);
                add_byte(BSLASH, fin && (n_dig == 0));
                for (int k = 0; k < n_dig; k++)
                    add_byte(DIGIT0 + 8'($urandom_range(0, 9)), fin && (k == n_dig - 1));
            end
        end
    endtask

    task automatic gen_raw_string();
        int         n_len;
        int         kind;
        logic [7:0] c;
        n_len = $urandom_range(1, 8);
        for (int t = 0; t < n_len; t++)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 5)
                c = BSLASH;
            else if (kind < 12)
                c = 8'($urandom_range(PRINT_LO, PRINT_HI));
            else
                c = 8'($urandom_range(0, 255));
            add_byte(c, t == n_len - 1);
        end
    endtask

    // sender: one transaction offered at a time, config writes only when drained
    always @(posedge clk)
    begin : driver
        plan_entry_t head;
        logic        offering;
        logic        nxt_we;
        offering = push;
        nxt_we   = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                escape_codec_predict(in_byte, in_last);
                n_accepted++;
                offering = 1'b0;
            end
            if (offering || expected_results.size() != 0)
                quiet_cnt = 0;
            else
                quiet_cnt++;
            if (!offering)
            begin
                if (tx_gap != 0)
                    tx_gap--;
                else if (plan.size() != 0)
                begin
                    head = plan[0];
                    case (head.kind)
                        ACT_BYTE:
                        begin
                            head = plan.pop_front();
                            in_byte <= head.data;
                            in_last <= head.last;
                            offering = 1'b1;
                            tx_gap = (hold_cnt != 0 || (n_loaded / 40) % 3 == 1)
                                     ? 0 : $urandom_range(0, 11);
                            n_loaded++;
                        end
                        ACT_DIR:
                        begin
                            if (quiet_cnt >= DRAIN_CYCLES)
                            begin
                                head = plan.pop_front();
                                nxt_we = 1'b1;
                                cfg_wdata <= head.data[0];
                                dir_q = head.data[0];
                                esc_q = ESC_IDLE;
                                acc_q = 8'h00;
                                err_q = 1'b0;
                                quiet_cnt = 0;
                                n_dir_writes++;
                            end
                        end
                        default:
                        begin
                            if (expected_results.size() == 0)
                                head = plan.pop_front();
                        end
                    endcase
                end
            end
        end
        push   <= offering;
        cfg_we <= nxt_we;
    end

    // one long receiver stall, counted here, once enough input has gone in
    always @(posedge clk)
    begin : long_hold
        if (rst_n)
        begin
            if (push && !full)
                hold_seen++;
            if (hold_cnt != 0)
                hold_cnt <= hold_cnt - 1;
            else if (!hold_done && hold_seen >= 150)
            begin
                hold_cnt  <= 90;
                hold_done <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        codec_result_t want;
        if (rst_n)
        begin
            if (rx_gap != 0)
                rx_gap--;
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected: out_byte %h", out_byte);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %h, got %h", want.data, out_byte);
                        fail_cnt++;
                    end
                    if (out_valid !== want.valid)
                    begin
                        $error("out_valid: expected %b, got %b", want.valid, out_valid);
                        fail_cnt++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last: expected %b, got %b", want.last, out_last);
                        fail_cnt++;
                    end
                    if (bad_input !== want.bad)
                    begin
                        $error("bad_input: expected %b, got %b", want.bad, bad_input);
                        fail_cnt++;
                    end
                end
                n_checked++;
                rx_gap = ((n_checked / 50) % 3 == 2) ? 0 : $urandom_range(0, 11);
            end
            pop <= (hold_cnt == 0) && (rx_gap == 0);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("timed out with %0d results outstanding", expected_results.size());
            $display("octal_escape_byte_codec verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   n_directed;
        int   n_str;
        int   phase;
        logic dir;

        // decode from reset: zero byte, backslash pair, octal value
        add_byte(8'h00, 1'b1);
        add_byte(BSLASH, 1'b0);
        add_byte(BSLASH, 1'b0);
        add_byte(BSLASH, 1'b0);
        add_byte(DIGIT0 + 8'd3, 1'b0);
        add_byte(DIGIT0 + 8'd7, 1'b0);
        add_byte(DIGIT0 + 8'd7, 1'b1);
        // digits beyond 7 (here 9) wrap modulo 256
        add_byte(BSLASH, 1'b0);
        add_byte(DIGIT9, 1'b0);
        add_byte(DIGIT9, 1'b0);
        add_byte(DIGIT9, 1'b1);
        // malformed after backslash, then in second and third digit place
        add_byte(BSLASH, 1'b0);
        add_byte(8'h71, 1'b0);
        add_byte(BSLASH, 1'b0);
        add_byte(DIGIT0 + 8'd1, 1'b0);
        add_byte(8'h7A, 1'b0);
        add_byte(BSLASH, 1'b0);
        add_byte(DIGIT0 + 8'd1, 1'b0);
        add_byte(DIGIT0 + 8'd2, 1'b0);
        add_byte(8'h21, 1'b1);
        // string ending right after a backslash
        add_byte(BSLASH, 1'b1);
        // half an escape left open; the direction write must clear it
        add_byte(BSLASH, 1'b0);
        add_byte(DIGIT0 + 8'd4, 1'b0);
        add_dir(DIR_ENCODE);
        add_byte(8'h00, 1'b0);
        add_byte(BSLASH, 1'b1);
        add_byte(8'h1F, 1'b0);
        add_byte(PRINT_LO, 1'b0);
        add_byte(PRINT_HI, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hFF, 1'b1);
        n_directed = n_planned;

        phase = 0;
        while (n_planned < n_directed + RANDOM_BYTES)
        begin
            dir = (phase % 2 == 0) ? DIR_DECODE : DIR_ENCODE;
            add_dir(dir);
            if (phase % 5 == 3)
                add_dir(dir);
            n_str = $urandom_range(4, 10);
            for (int s = 0; s < n_str && n_planned < n_directed + RANDOM_BYTES; s++)
            begin
                if (dir == DIR_DECODE)
                    gen_escaped_string();
                else
                    gen_raw_string();
                if ($urandom_range(0, 9) == 0)
                    add_sync();
            end
            if (dir == DIR_DECODE && $urandom_range(0, 3) == 0)
            begin
                add_byte(BSLASH, 1'b0);
                add_byte(DIGIT0 + 8'($urandom_range(0, 7)), 1'b0);
            end
            phase++;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (plan.size() != 0 || push)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("%0d bytes accepted over %0d direction writes; %0d results checked",
                 n_accepted, n_dir_writes, n_checked);
        $display("%0d decoded strings carried bad_input", n_bad_strings);
        if (fail_cnt == 0)
            $display("octal_escape_byte_codec verification clean");
        else
            $display("octal_escape_byte_codec verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/oebc_pkg.sv
rtl/oebc_front.sv
rtl/oebc_queue.sv
rtl/oebc_back.sv
rtl/octal_escape_byte_codec.sv
rtl/oebc_checker.sv
test/tb_octal_escape_byte_codec.sv
